/* src/taab_pkg.sv */
// taab_pkg: shared types, constants and CORDIC angle table for the
// transformed bounding-box pipeline. No dependencies.
`timescale 1ns / 1ps
package taab_pkg;

  localparam int unsigned CordicStages = 16;
  localparam int unsigned AtanEntries  = 24;
  localparam int unsigned NumStages    = (CordicStages < AtanEntries) ? CordicStages : AtanEntries;
  localparam int unsigned TrigW        = 34;  // Q2.30 plus growth headroom
  localparam int unsigned ZW           = 33;
  localparam logic signed [TrigW-1:0] CordicGain = 34'sh026DD3B6A;

  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [ZW-1:0]    ang_t;

  typedef struct packed {
    trig_t x;
    trig_t y;
    ang_t  z;
    logic [1:0] q;
  } cordic_t;

  // Everything that rides along with the angles through the CORDIC stages.
  typedef struct packed {
    logic signed [31:0] t_x, t_y, t_z;
    logic [47:0] sc;
    logic signed [31:0] lo_x, lo_y, lo_z;
    logic signed [31:0] hi_x, hi_y, hi_z;
  } side_t;

  function automatic ang_t atan_turn(input int unsigned i);
    logic [31:0] v;
    begin
      unique case (i)
        0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
        3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
        6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
        9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
        12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
        15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
        18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
        21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
        default: v = 32'h0;
      endcase
      return ang_t'({1'b0, v});
    end
  endfunction

  // Q2.30 product with round half up.
  function automatic trig_t mulq30(input trig_t a, input trig_t b);
    logic signed [2*TrigW-1:0] p;
    begin
      p = a * b + (68'sd1 <<< 29);
      return trig_t'(p >>> 30);
    end
  endfunction

endpackage

/* src/taab_cordic.sv */
// taab_cordic: pipelined rotation-mode CORDIC for three angles at once,
// one stage per register. Depends on taab_pkg.
`timescale 1ns / 1ps
module taab_cordic
  import taab_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [47:0] ang_i,
  input  side_t       side_i,
  output logic        vld_o,
  output trig_t       sin_o [3],
  output trig_t       cos_o [3],
  output side_t       side_o
);

  cordic_t st_q [NumStages+1][3];
  side_t   sd_q [NumStages+1];
  logic    v_q  [NumStages+1];
  cordic_t st_d [3];

  // Quadrant split feeding stage 0.
  always_comb begin
    logic [31:0] a32, d;
    logic [1:0]  q;
    for (int k = 0; k < 3; k++) begin
      a32 = {ang_i[16*k +: 16], 16'h0};
      q   = 2'((a32 + 32'h20000000) >> 30);
      d   = a32 - {q, 30'h0};
      st_d[k].x = CordicGain;
      st_d[k].y = '0;
      st_d[k].z = ang_t'(signed'(d));
      st_d[k].q = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NumStages; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= vld_i;
      for (int s = 0; s < NumStages; s++) v_q[s+1] <= v_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st_d;
      sd_q[0] <= side_i;
      for (int s = 0; s < NumStages; s++) begin
        sd_q[s+1] <= sd_q[s];
        for (int k = 0; k < 3; k++) begin
          st_q[s+1][k].q <= st_q[s][k].q;
          if (!st_q[s][k].z[ZW-1]) begin
            st_q[s+1][k].x <= st_q[s][k].x - (st_q[s][k].y >>> s);
            st_q[s+1][k].y <= st_q[s][k].y + (st_q[s][k].x >>> s);
            st_q[s+1][k].z <= st_q[s][k].z - atan_turn(s);
          end else begin
            st_q[s+1][k].x <= st_q[s][k].x + (st_q[s][k].y >>> s);
            st_q[s+1][k].y <= st_q[s][k].y - (st_q[s][k].x >>> s);
            st_q[s+1][k].z <= st_q[s][k].z + atan_turn(s);
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      unique case (st_q[NumStages][k].q)
        2'd0: begin cos_o[k] = st_q[NumStages][k].x;  sin_o[k] = st_q[NumStages][k].y;  end
        2'd1: begin cos_o[k] = -st_q[NumStages][k].y; sin_o[k] = st_q[NumStages][k].x;  end
        2'd2: begin cos_o[k] = -st_q[NumStages][k].x; sin_o[k] = -st_q[NumStages][k].y; end
        default: begin cos_o[k] = st_q[NumStages][k].y; sin_o[k] = -st_q[NumStages][k].x; end
      endcase
    end
  end

  assign vld_o  = v_q[NumStages];
  assign side_o = sd_q[NumStages];

endmodule

/* src/taab_matrix.sv */
// taab_matrix: three-stage rotation matrix build (pair products, triple
// products, sums). Depends on taab_pkg.
`timescale 1ns / 1ps
module taab_matrix
  import taab_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  trig_t sin_i [3],
  input  trig_t cos_i [3],
  input  side_t side_i,
  output logic  vld_o,
  output trig_t rm_o [9],
  output side_t side_o
);

  // stage A: pair products
  trig_t czcy_q, szcy_q, czsy_q, szsy_q, szcx_q, czcx_q, szsx_q, czsx_q;
  trig_t cycx_q, cysx_q, nsy_q, sx_q, cx_q;
  // stage B: triple products, plus the pair terms that ride to the sums
  trig_t b_q [9];
  trig_t c_q [4];
  trig_t rm_q [9];
  side_t sa_q, sb_q, sc_q;
  logic  va_q, vb_q, vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= vld_i; vb_q <= va_q; vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      czcy_q <= mulq30(cos_i[2], cos_i[1]);
      szcy_q <= mulq30(sin_i[2], cos_i[1]);
      czsy_q <= mulq30(cos_i[2], sin_i[1]);
      szsy_q <= mulq30(sin_i[2], sin_i[1]);
      szcx_q <= mulq30(sin_i[2], cos_i[0]);
      czcx_q <= mulq30(cos_i[2], cos_i[0]);
      szsx_q <= mulq30(sin_i[2], sin_i[0]);
      czsx_q <= mulq30(cos_i[2], sin_i[0]);
      cycx_q <= mulq30(cos_i[1], cos_i[0]);
      cysx_q <= mulq30(cos_i[1], sin_i[0]);
      nsy_q  <= -sin_i[1];
      sx_q   <= sin_i[0];
      cx_q   <= cos_i[0];
      sa_q   <= side_i;

      b_q[0] <= czcy_q;
      b_q[1] <= mulq30(czsy_q, sx_q);
      b_q[2] <= mulq30(czsy_q, cx_q);
      b_q[3] <= szcy_q;
      b_q[4] <= mulq30(szsy_q, sx_q);
      b_q[5] <= mulq30(szsy_q, cx_q);
      b_q[6] <= nsy_q;
      b_q[7] <= cysx_q;
      b_q[8] <= cycx_q;
      c_q[0] <= szcx_q;
      c_q[1] <= czcx_q;
      c_q[2] <= czsx_q;
      c_q[3] <= szsx_q;
      sb_q   <= sa_q;

      rm_q[0] <= b_q[0];
      rm_q[1] <= b_q[1] - c_q[0];
      rm_q[2] <= b_q[2] + c_q[3];
      rm_q[3] <= b_q[3];
      rm_q[4] <= b_q[4] + c_q[1];
      rm_q[5] <= b_q[5] - c_q[2];
      rm_q[6] <= b_q[6];
      rm_q[7] <= b_q[7];
      rm_q[8] <= b_q[8];
      sc_q    <= sb_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) rm_o[k] = rm_q[k];
  end

  assign vld_o  = vc_q;
  assign side_o = sc_q;

endmodule

/* src/taab_bounds.sv */
// taab_bounds: scaled matrix, corner products, sums, rounding and
// saturation, four register stages. Depends on taab_pkg.
`timescale 1ns / 1ps
module taab_bounds
  import taab_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  trig_t rm_i [9],
  input  side_t side_i,
  output logic  vld_o,
  output logic signed [31:0] wmin_o [3],
  output logic signed [31:0] wmax_o [3]
);

  logic signed [31:0] l_q [9];
  logic signed [63:0] a_q [9], b_q [9];
  logic signed [63:0] smin_q [3], smax_q [3];
  logic signed [31:0] mn_q [3], mx_q [3];
  side_t s1_q, s2_q;
  logic v1_q, v2_q, v3_q, v4_q;

  function automatic logic signed [31:0] rsat(input logic signed [63:0] v);
    logic signed [63:0] r;
    begin
      r = (v + 64'sd524288) >>> 20;
      if (r > 64'sd2147483647) return 32'sh7FFFFFFF;
      else if (r < -64'sd2147483648) return 32'sh80000000;
      else return r[31:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        l_q[k] <= 32'((($signed(rm_i[k]) * $signed(side_i.sc[16*(k%3) +: 16]))
                      + 50'sd131072) >>> 18);
      end
      s1_q <= side_i;
      for (int i = 0; i < 3; i++) begin
        a_q[3*i]   <= l_q[3*i]   * s1_q.lo_x;  b_q[3*i]   <= l_q[3*i]   * s1_q.hi_x;
        a_q[3*i+1] <= l_q[3*i+1] * s1_q.lo_y;  b_q[3*i+1] <= l_q[3*i+1] * s1_q.hi_y;
        a_q[3*i+2] <= l_q[3*i+2] * s1_q.lo_z;  b_q[3*i+2] <= l_q[3*i+2] * s1_q.hi_z;
      end
      s2_q <= s1_q;
      for (int i = 0; i < 3; i++) begin
        logic signed [63:0] t, mn, mx;
        t = (i == 0) ? 64'(s2_q.t_x) : (i == 1) ? 64'(s2_q.t_y) : 64'(s2_q.t_z);
        mn = t <<< 20; mx = t <<< 20;
        for (int j = 0; j < 3; j++) begin
          mn = mn + ((a_q[3*i+j] < b_q[3*i+j]) ? a_q[3*i+j] : b_q[3*i+j]);
          mx = mx + ((a_q[3*i+j] < b_q[3*i+j]) ? b_q[3*i+j] : a_q[3*i+j]);
        end
        smin_q[i] <= mn; smax_q[i] <= mx;
        mn_q[i] <= rsat(smin_q[i]); mx_q[i] <= rsat(smax_q[i]);
      end
    end
  end

  assign vld_o  = v4_q;
  assign wmin_o = mn_q;
  assign wmax_o = mx_q;

endmodule

/* src/trs_transform_aabb_bounds_unit.sv */
// trs_transform_aabb_bounds_unit: top level of the transformed bounding-box
// pipeline. Depends on taab_pkg, taab_cordic, taab_matrix, taab_bounds.
`timescale 1ns / 1ps
// One transaction in, one world box out, one transaction per cycle unless
// the output stalls. The CORDIC, matrix and bounds pipes advance together
// and freeze when the output holds a result that is not taken, so ready_o
// follows out ready or an empty output register.
module trs_transform_aabb_bounds_unit
  import taab_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] offset_x_i,
  input  logic signed [31:0] offset_y_i,
  input  logic signed [31:0] offset_z_i,
  input  logic [47:0]        rotation_angles_i,
  input  logic [47:0]        scale_factors_i,
  input  logic signed [31:0] local_min_x_i,
  input  logic signed [31:0] local_min_y_i,
  input  logic signed [31:0] local_min_z_i,
  input  logic signed [31:0] local_max_x_i,
  input  logic signed [31:0] local_max_y_i,
  input  logic signed [31:0] local_max_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] world_min_x_o,
  output logic signed [31:0] world_min_y_o,
  output logic signed [31:0] world_min_z_o,
  output logic signed [31:0] world_max_x_o,
  output logic signed [31:0] world_max_y_o,
  output logic signed [31:0] world_max_z_o
);

  logic  en;
  side_t side_in, side_c, side_m;
  logic  v_c, v_m;
  trig_t sn [3], cs [3], rm [9];
  logic signed [31:0] wmin [3], wmax [3];

  // Advance when the last stage is empty or being drained.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    side_in.t_x = offset_x_i;  side_in.t_y = offset_y_i;  side_in.t_z = offset_z_i;
    side_in.sc  = scale_factors_i;
    side_in.lo_x = local_min_x_i; side_in.lo_y = local_min_y_i; side_in.lo_z = local_min_z_i;
    side_in.hi_x = local_max_x_i; side_in.hi_y = local_max_y_i; side_in.hi_z = local_max_z_i;
  end

  taab_cordic u_cordic (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_valid_i), .ang_i(rotation_angles_i),
    .side_i(side_in), .vld_o(v_c), .sin_o(sn), .cos_o(cs), .side_o(side_c)
  );

  taab_matrix u_matrix (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_c), .sin_i(sn), .cos_i(cs),
    .side_i(side_c), .vld_o(v_m), .rm_o(rm), .side_o(side_m)
  );

  taab_bounds u_bounds (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_m), .rm_i(rm), .side_i(side_m),
    .vld_o(out_valid_o), .wmin_o(wmin), .wmax_o(wmax)
  );

  assign world_min_x_o = wmin[0];
  assign world_min_y_o = wmin[1];
  assign world_min_z_o = wmin[2];
  assign world_max_x_o = wmax[0];
  assign world_max_y_o = wmax[1];
  assign world_max_z_o = wmax[2];

endmodule

/* sim/tb.sv */
// tb: self-checking bench for trs_transform_aabb_bounds_unit. Streams boxes with
// random handshake gaps and compares every world box with a local predictor.
// Depends on taab_pkg and the unit RTL.
`timescale 1ns / 1ps
module tb;
  import taab_pkg::*;

  // One input transaction.
  typedef struct {
    logic signed [31:0] ox, oy, oz;
    logic [47:0] ang, scl;
    logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  } box_item_t;

  // One world box.
  typedef struct {
    logic signed [31:0] mn[3];
    logic signed [31:0] mx[3];
  } world_box_t;

  localparam int NumRandom = 1600;
  localparam int PipeDepth = CordicStages + 1 + 3 + 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] offset_x_i = '0, offset_y_i = '0, offset_z_i = '0;
  logic [47:0] rotation_angles_i = '0, scale_factors_i = '0;
  logic signed [31:0] local_min_x_i = '0, local_min_y_i = '0, local_min_z_i = '0;
  logic signed [31:0] local_max_x_i = '0, local_max_y_i = '0, local_max_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] world_min_x_o, world_min_y_o, world_min_z_o;
  logic signed [31:0] world_max_x_o, world_max_y_o, world_max_z_o;

  box_item_t pending_boxes[$];
  world_box_t expected_boxes[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit hold_sender = 1'b0;  // pressure: stop feeding until the pipe drains
  bit quiet_tail = 1'b0;   // no idling in the last part of the run
  int in_gap = 0, out_gap = 0;
  string field_names[6] = '{"world_min_x", "world_min_y", "world_min_z",
                            "world_max_x", "world_max_y", "world_max_z"};

  trs_transform_aabb_bounds_unit dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("** trs_transform_aabb_bounds_unit: FAILED **");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return floor_shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  // Quadrant split plus rotation-mode CORDIC, Q2.30 out.
  task automatic cordic_sincos(input logic [15:0] a16, output longint s, output longint c);
    logic [31:0] a32, d;
    logic [1:0] q;
    longint z, x, y, dx, dy;
    longint atan_tab[24] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
    a32 = {a16, 16'h0};
    q = 2'((a32 + 32'h20000000) >> 30);
    d = a32 - {q, 30'b0};
    z = longint'($signed(d));
    x = 'h26DD3B6A;
    y = 0;
    for (int i = 0; i < CordicStages && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic signed [31:0] round_clamp(longint v);
    longint r;
    r = floor_shr(v + (64'sd1 <<< 19), 20);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  task automatic predict_world_box(input box_item_t b, output world_box_t w);
    longint sx, cx, sy, cy, sz, cz, l, pa, pb, smin, smax;
    longint rot[3][3];
    longint t[3], lo[3], hi[3], sc[3];
    cordic_sincos(b.ang[15:0], sx, cx);
    cordic_sincos(b.ang[31:16], sy, cy);
    cordic_sincos(b.ang[47:32], sz, cz);
    rot[0][0] = q30_mul(cz, cy);
    rot[0][1] = q30_mul(q30_mul(cz, sy), sx) - q30_mul(sz, cx);
    rot[0][2] = q30_mul(q30_mul(cz, sy), cx) + q30_mul(sz, sx);
    rot[1][0] = q30_mul(sz, cy);
    rot[1][1] = q30_mul(q30_mul(sz, sy), sx) + q30_mul(cz, cx);
    rot[1][2] = q30_mul(q30_mul(sz, sy), cx) - q30_mul(cz, sx);
    rot[2][0] = -sy;
    rot[2][1] = q30_mul(cy, sx);
    rot[2][2] = q30_mul(cy, cx);
    t = '{longint'(b.ox), longint'(b.oy), longint'(b.oz)};
    lo = '{longint'(b.lo_x), longint'(b.lo_y), longint'(b.lo_z)};
    hi = '{longint'(b.hi_x), longint'(b.hi_y), longint'(b.hi_z)};
    for (int j = 0; j < 3; j++) sc[j] = longint'($signed(b.scl[16*j +: 16]));
    for (int i = 0; i < 3; i++) begin
      smin = t[i] * 1048576;
      smax = smin;
      for (int j = 0; j < 3; j++) begin
        l = floor_shr(rot[i][j] * sc[j] + (64'sd1 <<< 17), 18);
        pa = l * lo[j];
        pb = l * hi[j];
        smin += (pa < pb) ? pa : pb;
        smax += (pa < pb) ? pb : pa;
      end
      w.mn[i] = round_clamp(smin);
      w.mx[i] = round_clamp(smax);
    end
  endtask

  // ---------------- stimulus ----------------
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 'h3FFFF)) - 32'sd131072;  // near origin
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 7) * 16'h2000);  // octant edges
      1: return 16'($urandom_range(0, 3) * 16'h4000 + $urandom_range(0, 4) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(0, 4))
      0: return 16'h0100;
      1: return 16'h7FFF;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic box_item_t make_box(logic signed [31:0] c, logic [47:0] ang,
                                         logic [47:0] scl, logic signed [31:0] lo,
                                         logic signed [31:0] hi);
    box_item_t b;
    b.ox = c; b.oy = -c; b.oz = c;
    b.ang = ang; b.scl = scl;
    b.lo_x = lo; b.lo_y = lo; b.lo_z = lo;
    b.hi_x = hi; b.hi_y = hi; b.hi_z = hi;
    return b;
  endfunction

  initial begin
    box_item_t b;
    // Directed: identity, extremes, quadrant edges, swapped bounds, saturation.
    pending_boxes.push_back(make_box(0, '0, {3{16'h0100}}, -32'sh10000, 32'sh10000));
    pending_boxes.push_back(make_box(32'sh7FFFFFFF, '0, {3{16'h7FFF}},
                                     32'sh80000000, 32'sh7FFFFFFF));
    pending_boxes.push_back(make_box(32'sh80000000, {3{16'hFFFF}}, {3{16'h8000}},
                                     32'sh80000000, 32'sh7FFFFFFF));
    pending_boxes.push_back(make_box(32'sh12345, {3{16'h4000}}, {3{16'h0100}},
                                     32'sh20000, -32'sh20000));  // swapped bounds
    pending_boxes.push_back(make_box(-32'sh5000, {3{16'h8000}}, {3{16'hFF00}},
                                     -32'sh30000, 32'sh10000));
    pending_boxes.push_back(make_box(0, {3{16'hC000}}, '0, 32'sh80000000, 32'sh7FFFFFFF));
    pending_boxes.push_back(make_box(0, {3{16'h2000}}, {3{16'h0180}}, 0, 32'sh40000));
    pending_boxes.push_back(make_box(0, {3{16'hE000}}, {3{16'h0080}}, -32'sh40000, 0));
    pending_boxes.push_back(make_box(0, {16'h1FFF, 16'h6000, 16'hA000},
                                     {16'h0200, 16'hFE00, 16'h0100}, -32'sh1, 32'sh1));
    pending_boxes.push_back(make_box(32'sh7FFFFFFF, {16'h0001, 16'h7FFF, 16'hFFFE},
                                     {3{16'h7FFF}}, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    pending_boxes.push_back(make_box(32'sh80000000, {16'h8001, 16'h3FFF, 16'hBFFF},
                                     {3{16'h8000}}, 32'sh80000000, 32'sh80000000));
    pending_boxes.push_back(make_box(0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                                     32'shFFFFFFFF, 32'shFFFFFFFF));
    // Random part: mostly everyday boxes, with extremes mixed in.
    for (int n = 0; n < NumRandom; n++) begin
      b.ox = rand_coord(); b.oy = rand_coord(); b.oz = rand_coord();
      b.ang = {rand_angle(), rand_angle(), rand_angle()};
      b.scl = {rand_scale(), rand_scale(), rand_scale()};
      b.lo_x = rand_coord(); b.lo_y = rand_coord(); b.lo_z = rand_coord();
      b.hi_x = rand_coord(); b.hi_y = rand_coord(); b.hi_z = rand_coord();
      pending_boxes.push_back(b);
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------- driver ----------------
  int sent = 0;
  always @(posedge clk_i) begin
    box_item_t nb;
    world_box_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sent <= sent + 1;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        // previous transaction gone (or none): choose next
        if (sent == 400 && !hold_sender) hold_sender <= 1'b1;
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (hold_sender && expected_boxes.size() != 0 && sent >= 400
                     && !(in_valid_i && in_ready_o)) begin
          in_valid_i <= 1'b0;
        end else if (pending_boxes.size() == 0) begin
          in_valid_i <= 1'b0;
          stim_done <= 1'b1;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 7);
          in_valid_i <= 1'b0;
        end else begin
          if (hold_sender && expected_boxes.size() == 0) hold_sender <= 1'b0;
          nb = pending_boxes.pop_front();
          predict_world_box(nb, w);
          expected_boxes.push_back(w);
          in_valid_i <= 1'b1;
          offset_x_i <= nb.ox; offset_y_i <= nb.oy; offset_z_i <= nb.oz;
          rotation_angles_i <= nb.ang; scale_factors_i <= nb.scl;
          local_min_x_i <= nb.lo_x; local_min_y_i <= nb.lo_y; local_min_z_i <= nb.lo_z;
          local_max_x_i <= nb.hi_x; local_max_y_i <= nb.hi_y; local_max_z_i <= nb.hi_z;
          if (pending_boxes.size() < 150) quiet_tail <= 1'b1;
        end
      end
    end
  end

  // Pressure pause: once hold_sender is set after 400 transactions, the driver
  // sends nothing more until the expected queue is empty, then clears it.
  // (sent does not grow during the pause, so sent >= 400 keeps holding.)

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    world_box_t e;
    logic signed [31:0] got[6];
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{world_min_x_o, world_min_y_o, world_min_z_o,
                world_max_x_o, world_max_y_o, world_max_z_o};
        if (expected_boxes.size() == 0) begin
          $error("world box with no transaction outstanding");
          errors++;
        end else begin
          e = expected_boxes.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (got[i] !== e.mn[i]) begin
              $error("%s expected %0d got %0d", field_names[i], e.mn[i], got[i]);
              errors++;
            end
            if (got[3+i] !== e.mx[i]) begin
              $error("%s expected %0d got %0d", field_names[3+i], e.mx[i], got[3+i]);
              errors++;
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------- end of run ----------------
  initial begin
    wait (stim_done);
    wait (expected_boxes.size() == 0);
    repeat (PipeDepth + 20) @(posedge clk_i);
    if (errors == 0 && expected_boxes.size() == 0)
      $display("** trs_transform_aabb_bounds_unit: PASSED **");
    else
      $display("** trs_transform_aabb_bounds_unit: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
src/taab_pkg.sv
src/taab_cordic.sv
src/taab_matrix.sv
src/taab_bounds.sv
src/trs_transform_aabb_bounds_unit.sv
sim/tb.sv
